// ===== hw/rtl/hhc_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes and types for the heat histogram colormap core.
// No dependencies.
package hhc_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_DECAY = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_WIDTH     = 3'd1;
    localparam logic [2:0] CFG_HEIGHT    = 3'd2;
    localparam logic [2:0] CFG_STOP_LOW  = 3'd3;
    localparam logic [2:0] CFG_STOP_MID  = 3'd4;
    localparam logic [2:0] CFG_STOP_HIGH = 3'd5;

    // Update modes
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_DECAY   = 2'd2;

    // Q24.8 count constants and the Q1.16 decay factor of one
    localparam logic [31:0] Q8_ONE    = 32'd256;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FEFF;
    localparam logic [16:0] FACTOR_ONE = 17'd65536;

    // Three RGBA color stops, red in the low byte
    typedef struct packed {
        logic [31:0] stop_high;
        logic [31:0] stop_mid;
        logic [31:0] stop_low;
    } hhc_stops_t;

endpackage

// ===== hw/rtl/heat_histogram_colormap_core.sv =====
`timescale 1ns / 1ps
// Heat histogram colormap core: 2D point histogram in one block RAM with a
// colored read-out. Depends on hhc_pkg, hhc_bin, hhc_level and hhc_color.
//
// Items are handled one at a time; the counts live in a single-port-write,
// registered-read RAM of MAX_GRID_W*MAX_GRID_H words. An add runs two binning
// stages, a RAM read and a write back; a read runs a RAM read, the level
// divider, a lerp stage and the output register; a clear writes one RAM word
// a cycle, and a decay tick reads, multiplies and writes back each word. After
// reset, and after any grid size change, a clearing pass runs while s_tready
// stays low; configuration writes are accepted at all times. A finished color
// waits in the output register while the next item is taken.
module heat_histogram_colormap_core #(
    parameter int MAX_GRID_W = 64,
    parameter int MAX_GRID_H = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // point_x, point_y, batch_start, decay_factor, cell_index
    input  logic [1:0]  s_tuser,   // func
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_alpha, heat_level
    output logic        m_tuser,   // index_error
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);
    import hhc_pkg::*;

    localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_GRID_W + 1);
    localparam int HW    = $clog2(MAX_GRID_H + 1);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_CLEAR   = 13'b0000000000010,
        ST_ADD_BIN = 13'b0000000000100,
        ST_ADD_IDX = 13'b0000000001000,
        ST_ADD_RD  = 13'b0000000010000,
        ST_ADD_WR  = 13'b0000000100000,
        ST_DEC_RD  = 13'b0000001000000,
        ST_DEC_MUL = 13'b0000010000000,
        ST_DEC_WR  = 13'b0000100000000,
        ST_RD_CHK  = 13'b0001000000000,
        ST_RD_DATA = 13'b0010000000000,
        ST_RD_DIV  = 13'b0100000000000,
        ST_RD_OUT  = 13'b1000000000000
    } state_t;

    state_t      state_reg;
    logic        lerp_reg;

    // configuration
    logic [1:0]  mode_reg;
    logic [6:0]  gw_reg, gh_reg;
    hhc_stops_t  stops_reg;
    logic [WW-1:0] w_eff, w_new;
    logic [HW-1:0] h_eff, h_new;
    logic [CW-1:0] area_reg;
    logic        grid_chg;

    // latched item
    logic [1:0]  func_in;
    logic signed [15:0] x_in, y_in;
    logic        bs_in;
    logic [16:0] f_in;
    logic [11:0] ci_in;
    logic signed [15:0] x_reg, y_reg;
    logic [16:0] f_reg;
    logic [11:0] ci_reg;
    logic        drop_reg, add_pend_reg, err_reg;

    // store and sweep
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;
    logic [AW-1:0] cnt_reg;
    logic [31:0] peak_reg, nmax_reg, nmax_new, inc_val, dec_val;
    logic [47:0] prod_reg;
    logic [AW-1:0] bin_idx;

    // level and color
    logic        div_start, div_done;
    logic [7:0]  div_level;
    logic [31:0] pixel;

    // output register
    logic        m_valid_reg;
    logic [39:0] m_data_reg;
    logic        m_user_reg;
    logic        out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign func_in = s_tuser;
    assign x_in    = $signed(s_tdata[15:0]);
    assign y_in    = $signed(s_tdata[31:16]);
    assign bs_in   = s_tdata[32];
    assign f_in    = s_tdata[49:33];
    assign ci_in   = s_tdata[61:50];

    // lerp result is ready once the lerp start strobe has loaded t_reg
    assign out_load = (state_reg == ST_RD_OUT) && !lerp_reg && (!m_valid_reg || m_tready);

    function automatic logic [WW-1:0] eff_w(input logic [6:0] v);
        if (v == 7'd0) return WW'(1);
        else if (32'(v) > MAX_GRID_W) return WW'(MAX_GRID_W);
        else return WW'(v);
    endfunction

    function automatic logic [HW-1:0] eff_h(input logic [6:0] v);
        if (v == 7'd0) return HW'(1);
        else if (32'(v) > MAX_GRID_H) return HW'(MAX_GRID_H);
        else return HW'(v);
    endfunction

    // Effective grid and the size a write would leave
    always_comb begin
        w_eff = eff_w(gw_reg);
        h_eff = eff_h(gh_reg);
        w_new = (cfg_addr == CFG_WIDTH)  ? eff_w(cfg_data[6:0]) : w_eff;
        h_new = (cfg_addr == CFG_HEIGHT) ? eff_h(cfg_data[6:0]) : h_eff;
        grid_chg = cfg_valid && (w_new != w_eff || h_new != h_eff);
    end

    // Count update values
    always_comb begin
        inc_val  = (rd_data_reg > COUNT_TOP) ? 32'hFFFF_FFFF : rd_data_reg + Q8_ONE;
        dec_val  = prod_reg[47:16];
        nmax_new = (dec_val > nmax_reg) ? dec_val : nmax_reg;
    end

    // RAM port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = 32'd0;
        mem_raddr = cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_ADD_RD: begin
                mem_raddr = bin_idx;
            end
            ST_ADD_WR: begin
                mem_we    = 1'b1;
                mem_waddr = bin_idx;
                mem_wdata = inc_val;
            end
            ST_DEC_WR: begin
                mem_we    = 1'b1;
                mem_wdata = dec_val;
            end
            ST_RD_CHK: begin
                mem_raddr = AW'(ci_reg);
            end
            default: ;
        endcase
    end

    // Count store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Grid area for the read range check
    always_ff @(posedge aclk) begin
        area_reg <= CW'(w_eff) * CW'(h_eff);
    end

    // Decay product
    always_ff @(posedge aclk) begin
        prod_reg <= rd_data_reg * f_reg;
    end

    assign div_start = (state_reg == ST_RD_DATA);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            add_pend_reg <= 1'b0;
            peak_reg     <= Q8_ONE;
            mode_reg     <= 2'd0;
            gw_reg       <= 7'd64;
            gh_reg       <= 7'd64;
            stops_reg.stop_low  <= 32'd671088895;
            stops_reg.stop_mid  <= 32'd4294948864;
            stops_reg.stop_high <= 32'd4278205695;
            m_valid_reg  <= 1'b0;
            lerp_reg     <= 1'b0;
        end else begin
            lerp_reg <= 1'b0;

            // Output register: load a finished color or an index-error result, or drain on transfer
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_user_reg  <= err_reg;
                m_data_reg  <= err_reg ? 40'd0 : {div_level, pixel};
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // A grid size change wipes the store
            if (grid_chg) begin
                state_reg <= ST_CLEAR;
                cnt_reg   <= '0;
                peak_reg  <= Q8_ONE;
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        if (s_tvalid) begin
                            x_reg    <= x_in;
                            y_reg    <= y_in;
                            ci_reg   <= ci_in;
                            f_reg    <= (f_in > FACTOR_ONE) ? FACTOR_ONE : f_in;
                            drop_reg <= (x_in < -16'sd16384) || (x_in > 16'sd16384) ||
                                        (y_in < -16'sd16384) || (y_in > 16'sd16384);
                            cnt_reg  <= '0;
                            nmax_reg <= 32'd0;
                            case (func_in)
                                FUNC_ADD: begin
                                    if (mode_reg == MODE_REPLACE && bs_in) begin
                                        state_reg    <= ST_CLEAR;
                                        add_pend_reg <= 1'b1;
                                        peak_reg     <= Q8_ONE;
                                    end else if ((x_in < -16'sd16384) ||
                                                 (x_in > 16'sd16384) ||
                                                 (y_in < -16'sd16384) ||
                                                 (y_in > 16'sd16384)) begin
                                        state_reg <= ST_IDLE;
                                    end else begin
                                        state_reg <= ST_ADD_BIN;
                                    end
                                end
                                FUNC_CLEAR: begin
                                    state_reg <= ST_CLEAR;
                                    peak_reg  <= Q8_ONE;
                                end
                                FUNC_DECAY: begin
                                    if (mode_reg == MODE_DECAY) begin
                                        state_reg <= ST_DEC_RD;
                                    end
                                end
                                default: begin
                                    state_reg <= ST_RD_CHK;
                                end
                            endcase
                        end
                    end
                    ST_CLEAR: begin
                        cnt_reg <= cnt_reg + AW'(1);
                        if (cnt_reg == LAST_ADDR) begin
                            add_pend_reg <= 1'b0;
                            state_reg    <= (add_pend_reg && !drop_reg) ? ST_ADD_BIN
                                                                        : ST_IDLE;
                        end
                    end
                    ST_ADD_BIN: state_reg <= ST_ADD_IDX;
                    ST_ADD_IDX: state_reg <= ST_ADD_RD;
                    ST_ADD_RD:  state_reg <= ST_ADD_WR;
                    ST_ADD_WR: begin
                        if (inc_val > peak_reg) begin
                            peak_reg <= inc_val;
                        end
                        state_reg <= ST_IDLE;
                    end
                    ST_DEC_RD:  state_reg <= ST_DEC_MUL;
                    ST_DEC_MUL: state_reg <= ST_DEC_WR;
                    ST_DEC_WR: begin
                        nmax_reg <= nmax_new;
                        cnt_reg  <= cnt_reg + AW'(1);
                        if (cnt_reg == LAST_ADDR) begin
                            peak_reg  <= (nmax_new > Q8_ONE) ? nmax_new : Q8_ONE;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_DEC_RD;
                        end
                    end
                    ST_RD_CHK: begin
                        if (32'(ci_reg) >= 32'(area_reg)) begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_RD_OUT;
                        end else begin
                            err_reg   <= 1'b0;
                            state_reg <= ST_RD_DATA;
                        end
                    end
                    ST_RD_DATA: state_reg <= ST_RD_DIV;
                    ST_RD_DIV: begin
                        if (div_done) begin
                            lerp_reg  <= 1'b1;
                            state_reg <= ST_RD_OUT;
                        end
                    end
                    ST_RD_OUT: begin
                        if (out_load) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end

            // Register writes
            if (cfg_valid) begin
                case (cfg_addr)
                    CFG_MODE:      mode_reg <= cfg_data[1:0];
                    CFG_WIDTH:     gw_reg   <= cfg_data[6:0];
                    CFG_HEIGHT:    gh_reg   <= cfg_data[6:0];
                    CFG_STOP_LOW:  stops_reg.stop_low  <= cfg_data;
                    CFG_STOP_MID:  stops_reg.stop_mid  <= cfg_data;
                    CFG_STOP_HIGH: stops_reg.stop_high <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    hhc_bin #(
        .MAX_GRID_W (MAX_GRID_W),
        .MAX_GRID_H (MAX_GRID_H)
    ) u_bin (
        .aclk     (aclk),
        .point_x  (x_reg),
        .point_y  (y_reg),
        .grid_w   (w_eff),
        .grid_h   (h_eff),
        .cell_idx (bin_idx)
    );

    hhc_level u_level (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .count   (rd_data_reg),
        .peak    (peak_reg),
        .done    (div_done),
        .level   (div_level)
    );

    hhc_color u_color (
        .aclk  (aclk),
        .start (lerp_reg),
        .level (div_level),
        .stops (stops_reg),
        .pixel (pixel)
    );

`ifndef NO_ASSERTIONS
    a_peak_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= Q8_ONE)
        else $error("peak fell below 1.0");

    a_err_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 40'd0))
        else $error("index error result carries color data");

    a_no_update_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != FUNC_READ) |=> !$rose(m_tvalid))
        else $error("update item produced a result");
`endif

endmodule

// ===== hw/rtl/hhc_bin.sv =====
`timescale 1ns / 1ps
// Point binning: Q1.14 coordinates to a flat cell address, two register stages.
// Depends on nothing outside this file.
module hhc_bin #(
    parameter int MAX_GRID_W = 64,
    parameter int MAX_GRID_H = 64
) (
    input  logic                                  aclk,
    input  logic signed [15:0]                    point_x,
    input  logic signed [15:0]                    point_y,
    input  logic [$clog2(MAX_GRID_W+1)-1:0]       grid_w,
    input  logic [$clog2(MAX_GRID_H+1)-1:0]       grid_h,
    output logic [((MAX_GRID_W*MAX_GRID_H > 1) ?
                   $clog2(MAX_GRID_W*MAX_GRID_H) : 1)-1:0] cell_idx
);
    localparam int WW    = $clog2(MAX_GRID_W + 1);
    localparam int HW    = $clog2(MAX_GRID_H + 1);
    localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0]      ux, uy;
    logic [15+WW:0]   px;
    logic [15+HW:0]   py;
    logic [WW-1:0]    ix_raw, ix_next, ix_reg;
    logic [HW-1:0]    iy_raw, iy_next, iy_reg;

    // Offset to 0..32768 with y flipped so +1 lands on row 0
    assign ux = 16'(17'(point_x) + 17'sd16384);
    assign uy = 16'(17'sd16384 - 17'(point_y));
    assign px = ux * grid_w;
    assign py = uy * grid_h;
    assign ix_raw = WW'(px >> 15);
    assign iy_raw = HW'(py >> 15);

    // Clamp the edge coordinate into the last cell
    always_comb begin
        ix_next = (ix_raw >= grid_w) ? grid_w - WW'(1) : ix_raw;
        iy_next = (iy_raw >= grid_h) ? grid_h - HW'(1) : iy_raw;
    end

    always_ff @(posedge aclk) begin
        ix_reg   <= ix_next;
        iy_reg   <= iy_next;
        cell_idx <= AW'(32'(iy_reg) * 32'(grid_w) + 32'(ix_reg));
    end

endmodule

// ===== hw/rtl/hhc_level.sv =====
`timescale 1ns / 1ps
// Level divider: min(255, floor(count*255/peak)), one quotient bit a cycle.
// Depends on nothing outside this file.
module hhc_level (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] count,
    input  logic [31:0] peak,
    output logic        done,
    output logic [7:0]  level
);
    logic [39:0] rem_reg;
    logic [38:0] dvs_reg;
    logic [7:0]  q_reg;
    logic [2:0]  step_reg;
    logic        run_reg;
    logic        done_reg;
    logic        fits;

    assign fits  = rem_reg >= 40'(dvs_reg);
    assign done  = done_reg;
    assign level = q_reg;

    // Restoring division; count below peak keeps the quotient in 8 bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (count >= peak) begin
                    q_reg    <= 8'hFF;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= {count, 8'h00} - 40'(count);
                    dvs_reg  <= {peak, 7'h00};
                    q_reg    <= 8'h00;
                    step_reg <= 3'd0;
                    run_reg  <= 1'b1;
                end
            end else if (run_reg) begin
                if (fits) begin
                    rem_reg <= rem_reg - 40'(dvs_reg);
                end
                q_reg    <= {q_reg[6:0], fits};
                dvs_reg  <= dvs_reg >> 1;
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/hhc_color.sv =====
`timescale 1ns / 1ps
// Color lerp over three stops: level to RGBA, exact floor of t/255.
// Depends on hhc_pkg.
module hhc_color (
    input  logic              aclk,
    input  logic              start,
    input  logic [7:0]        level,
    input  hhc_pkg::hhc_stops_t stops,
    output logic [31:0]       pixel     // r [7:0], g [15:8], b [23:16], a [31:24]
);
    import hhc_pkg::*;

    logic [8:0]  num2;
    logic [7:0]  num;
    logic [31:0] sa, sb;
    logic [15:0] t_reg [4];

    // Lower half blends low..mid, upper half mid..high
    always_comb begin
        num2 = {level, 1'b0};
        if (num2 < 9'd255) begin
            sa  = stops.stop_low;
            sb  = stops.stop_mid;
            num = num2[7:0];
        end else begin
            sa  = stops.stop_mid;
            sb  = stops.stop_high;
            num = 8'(num2 - 9'd255);
        end
    end

    // t = a*(255-num) + b*num, at most 255*255
    always_ff @(posedge aclk) begin
        if (start) begin
            for (int i = 0; i < 4; i++) begin
                t_reg[i] <= 16'(sa[8*i +: 8]) * 16'(8'd255 - num)
                          + 16'(sb[8*i +: 8]) * 16'(num);
            end
        end
    end

    // floor(t/255) = (t + 1 + (t >> 8)) >> 8 for t below 65535
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pixel[8*i +: 8] = 8'((17'(t_reg[i]) + 17'd1 + 17'(t_reg[i] >> 8)) >> 8);
        end
    end

endmodule
